// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_CLK_RST(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/lla3_pkg.sv =====
// types, codes and rule function of the 3d life-like automaton
package lla3_pkg;

  localparam int MASK_W = 27;
  localparam int CNT_W  = 5;

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_ADVANCE = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;

  localparam logic [1:0] ST_DEAD  = 2'd0;
  localparam logic [1:0] ST_LIVE  = 2'd1;
  localparam logic [1:0] ST_DYING = 2'd2;

  localparam logic [1:0] REG_BORN  = 2'd0;
  localparam logic [1:0] REG_STAY  = 2'd1;
  localparam logic [1:0] REG_THREE = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] cell_x;
    logic [3:0] cell_y;
    logic [3:0] cell_z;
    logic [1:0] new_state;
  } in_t;

  typedef struct packed {
    logic [1:0] read_state;
    logic       op_done;
  } out_t;

  function automatic logic [1:0] next_state(input logic [1:0] cur, input logic [CNT_W-1:0] cnt,
                                            input logic [MASK_W-1:0] born,
                                            input logic [MASK_W-1:0] stay,
                                            input logic three);
    logic [1:0] nxt;
    nxt = ST_DEAD;
    if (cur == ST_DEAD) begin
      nxt = born[cnt] ? ST_LIVE : ST_DEAD;
    end else if (cur == ST_LIVE) begin
      if (stay[cnt]) nxt = ST_LIVE;
      else nxt = three ? ST_DYING : ST_DEAD;
    end
    return nxt;
  endfunction

endpackage

// ===== rtl/core/lla3_ram.sv =====
// generic single write, single registered read ram
module lla3_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/life_like_3d_automaton_top.sv =====
// top level of the 3d life-like automaton with dying state
// usage:
//   input channel in_valid/in_stall carries one transaction: write a cell,
//   read a cell, or advance one generation. output channel out_valid/out_stall
//   returns one result per transaction (read_state, op_done).
//   config channel cfg_valid/cfg_ready writes born mask, stay mask, mode
//   by cfg_index; cfg_ready is always high.
// operation:
//   a write is done when it is taken, a read returns the registered ram data in S_RD;
//   an advance visits every cell: per cell the single ram read port fetches
//   the 27 cells of the neighborhood one a cycle, then a drain and a write
//   state follow. grids ping-pong between two rams, no copy back.
//   one transaction at a time; the next one is taken once the result left.
// reset:
//   rst clears the current grid in a pass over all GRID_SIDE^3 cells, with
//   in_stall high meanwhile. control and mask regs reset to zero, data regs not.
// stalls:
//   a result waits in the output register while out_stall is high, and
//   in_stall stays high until it has gone.
module life_like_3d_automaton_top #(
  parameter int GRID_SIDE = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  lla3_pkg::in_t             in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output lla3_pkg::out_t            out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [lla3_pkg::MASK_W-1:0] cfg_data
);
  import lla3_pkg::*;
  `include "assert_macros.svh"

  localparam int CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int CW    = $clog2(GRID_SIDE);
  localparam int AW    = $clog2(CELLS);
  localparam logic [AW-1:0]   SS   = AW'(GRID_SIDE * GRID_SIDE);
  localparam logic [AW-1:0]   S_A  = AW'(GRID_SIDE);
  localparam logic [CW-1:0]   SMAX = CW'(GRID_SIDE - 1);
  localparam logic [CW:0]     SEXT = (CW+1)'(GRID_SIDE);
  localparam logic [AW-1:0]   LAST = AW'(CELLS - 1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RD, S_GEN, S_DRAIN, S_GWR} state_t;

  state_t            state;
  logic              bank;
  logic [AW-1:0]     clr_addr;
  logic [CW-1:0]     cx, cy, cz;
  logic [1:0]        dx, dy, dz;
  logic              pend_valid, pend_inb, pend_center;
  logic [CNT_W-1:0]  cnt;
  logic [1:0]        cur;
  logic              rd_inside;
  logic [MASK_W-1:0] born_mask, stay_mask;
  logic              three_state_mode;

  logic              accept, in_grid;
  logic [AW-1:0]     in_addr, cell_addr, nb_addr, raddr;
  logic [CW:0]       sx, sy, sz;
  logic              nb_inb;
  logic              wr_cur_en, wr_oth_en;
  logic [AW-1:0]     wr_cur_addr;
  logic [1:0]        wr_cur_data, wr_oth_data;
  logic              we0, we1;
  logic [AW-1:0]     wa0, wa1;
  logic [1:0]        wd0, wd1, rd0, rd1, rdata;

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                            input logic [CW-1:0] z);
    return AW'(AW'(x) * SS + AW'(y) * S_A + AW'(z));
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE) || out_valid;
  assign accept    = in_valid && !in_stall;
  assign in_grid   = ({3'b0, in_data.cell_x} < 7'(GRID_SIDE)) &&
                     ({3'b0, in_data.cell_y} < 7'(GRID_SIDE)) &&
                     ({3'b0, in_data.cell_z} < 7'(GRID_SIDE));
  assign in_addr   = addr_of(CW'(in_data.cell_x), CW'(in_data.cell_y), CW'(in_data.cell_z));
  assign cell_addr = addr_of(cx, cy, cz);

  assign sx      = (CW+1)'(cx) + (CW+1)'(dx);
  assign sy      = (CW+1)'(cy) + (CW+1)'(dy);
  assign sz      = (CW+1)'(cz) + (CW+1)'(dz);
  assign nb_inb  = (sx != '0) && (sx <= SEXT) && (sy != '0) && (sy <= SEXT) &&
                   (sz != '0) && (sz <= SEXT);
  assign nb_addr = addr_of(CW'(sx - 1'b1), CW'(sy - 1'b1), CW'(sz - 1'b1));

  always_comb begin
    unique case (state)
      S_GEN:   raddr = nb_addr;
      default: raddr = in_addr;
    endcase
  end

  assign wr_cur_en   = (state == S_CLEAR) ||
                       (accept && in_data.action == ACT_WRITE && in_grid &&
                        in_data.new_state <= ST_DYING);
  assign wr_cur_addr = (state == S_CLEAR) ? clr_addr : in_addr;
  assign wr_cur_data = (state == S_CLEAR) ? ST_DEAD : in_data.new_state;
  assign wr_oth_en   = (state == S_GWR);
  assign wr_oth_data = next_state(cur, cnt, born_mask, stay_mask, three_state_mode);

  assign we0 = bank ? wr_oth_en : wr_cur_en;
  assign wa0 = bank ? cell_addr : wr_cur_addr;
  assign wd0 = bank ? wr_oth_data : wr_cur_data;
  assign we1 = bank ? wr_cur_en : wr_oth_en;
  assign wa1 = bank ? wr_cur_addr : cell_addr;
  assign wd1 = bank ? wr_cur_data : wr_oth_data;
  assign rdata = bank ? rd1 : rd0;

  lla3_ram #(.WIDTH(2), .DEPTH(CELLS)) u_ram0 (
    .clk(clk), .we(we0), .waddr(wa0), .wdata(wd0), .raddr(raddr), .rdata(rd0)
  );
  lla3_ram #(.WIDTH(2), .DEPTH(CELLS)) u_ram1 (
    .clk(clk), .we(we1), .waddr(wa1), .wdata(wd1), .raddr(raddr), .rdata(rd1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      bank             <= 1'b0;
      clr_addr         <= '0;
      out_valid        <= 1'b0;
      pend_valid       <= 1'b0;
      cnt              <= '0;
      born_mask        <= '0;
      stay_mask        <= '0;
      three_state_mode <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_BORN:  born_mask <= cfg_data;
          REG_STAY:  stay_mask <= cfg_data;
          REG_THREE: three_state_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (pend_valid) begin
        if (pend_center) cur <= rdata;
        else if (pend_inb && rdata == ST_LIVE) cnt <= cnt + 1'b1;
      end
      pend_valid <= (state == S_GEN);
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            rd_inside <= in_grid;
            priority if (in_data.action == ACT_READ) begin
              state <= S_RD;
            end else if (in_data.action == ACT_ADVANCE) begin
              cx <= '0; cy <= '0; cz <= '0;
              dx <= '0; dy <= '0; dz <= '0;
              cnt <= '0;
              state <= S_GEN;
            end else begin
              out_valid           <= 1'b1;
              out_data.read_state <= ST_DEAD;
              out_data.op_done    <= (in_data.action == ACT_WRITE);
            end
          end
        end
        S_RD: begin
          out_valid           <= 1'b1;
          out_data.read_state <= rd_inside ? rdata : ST_DEAD;
          out_data.op_done    <= 1'b1;
          state               <= S_IDLE;
        end
        S_GEN: begin
          pend_inb    <= nb_inb;
          pend_center <= (dx == 2'd1) && (dy == 2'd1) && (dz == 2'd1);
          if (dz == 2'd2) begin
            dz <= '0;
            if (dy == 2'd2) begin
              dy <= '0;
              if (dx == 2'd2) begin
                dx    <= '0;
                state <= S_DRAIN;
              end else dx <= dx + 1'b1;
            end else dy <= dy + 1'b1;
          end else dz <= dz + 1'b1;
        end
        S_DRAIN: state <= S_GWR;
        S_GWR: begin
          cnt   <= '0;
          state <= S_GEN;
          if (cz == SMAX) begin
            cz <= '0;
            if (cy == SMAX) begin
              cy <= '0;
              if (cx == SMAX) begin
                cx                  <= '0;
                bank                <= !bank;
                out_valid           <= 1'b1;
                out_data.read_state <= ST_DEAD;
                out_data.op_done    <= 1'b1;
                state               <= S_IDLE;
              end else cx <= cx + 1'b1;
            end else cy <= cy + 1'b1;
          end else cz <= cz + 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK_RST(a_clear_after_reset, rst |=> in_stall, "input taken during clearing pass")
  `ASSERT_CLK(a_busy_after_accept, accept |=> in_stall, "second transaction taken while busy")
  `ASSERT_CLK(a_count_range, cnt <= CNT_W'(26), "neighbor count above 26")
  `ASSERT_CLK(a_no_pend_at_write, (state == S_GWR) |-> !pend_valid,
              "cell written before its last neighbor arrived")

endmodule

// ===== verif/life_like_3d_automaton_checker.sv =====
// checker for the 3d life-like automaton: grid predictor and result compare
`timescale 1ns / 1ps
module life_like_3d_automaton_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  lla3_pkg::in_t               in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  lla3_pkg::out_t              out_data,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [lla3_pkg::MASK_W-1:0] cfg_data,
  output int                          fail_count,
  output int                          pending
);
  import lla3_pkg::*;

  localparam int SIDE = 16;
  localparam int CELLS = SIDE * SIDE * SIDE;

  logic [1:0]        grid[CELLS];
  logic [1:0]        grid_nxt[CELLS];
  logic [MASK_W-1:0] born_bits;
  logic [MASK_W-1:0] stay_bits;
  logic              dying_mode;
  out_t              expected_q[$];

  function automatic int cell_at(int x, int y, int z);
    return (x * SIDE + y) * SIDE + z;
  endfunction

  function automatic int live_neighbors(int x, int y, int z);
    int n;
    n = 0;
    for (int dx = -1; dx <= 1; dx++)
      for (int dy = -1; dy <= 1; dy++)
        for (int dz = -1; dz <= 1; dz++)
          if ((dx != 0 || dy != 0 || dz != 0) &&
              x + dx >= 0 && x + dx < SIDE && y + dy >= 0 && y + dy < SIDE &&
              z + dz >= 0 && z + dz < SIDE &&
              grid[cell_at(x + dx, y + dy, z + dz)] == ST_LIVE)
            n++;
    return n;
  endfunction

  function automatic void step_generation();
    int n;
    logic [1:0] cur;
    for (int x = 0; x < SIDE; x++)
      for (int y = 0; y < SIDE; y++)
        for (int z = 0; z < SIDE; z++) begin
          n = live_neighbors(x, y, z);
          cur = grid[cell_at(x, y, z)];
          if (cur == ST_DEAD) begin
            grid_nxt[cell_at(x, y, z)] = born_bits[n] ? ST_LIVE : ST_DEAD;
          end else if (cur == ST_LIVE) begin
            if (stay_bits[n]) grid_nxt[cell_at(x, y, z)] = ST_LIVE;
            else grid_nxt[cell_at(x, y, z)] = dying_mode ? ST_DYING : ST_DEAD;
          end else begin
            grid_nxt[cell_at(x, y, z)] = ST_DEAD;
          end
        end
    for (int i = 0; i < CELLS; i++) grid[i] = grid_nxt[i];
  endfunction

  function automatic out_t predict_result(in_t t);
    out_t r;
    r = '0;
    case (t.action)
      ACT_WRITE: begin
        if (t.new_state != 2'd3) grid[cell_at(t.cell_x, t.cell_y, t.cell_z)] = t.new_state;
        r.op_done = 1'b1;
      end
      ACT_ADVANCE: begin
        step_generation();
        r.op_done = 1'b1;
      end
      ACT_READ: begin
        r.read_state = grid[cell_at(t.cell_x, t.cell_y, t.cell_z)];
        r.op_done = 1'b1;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) grid[i] = ST_DEAD;
      born_bits = '0;
      stay_bits = '0;
      dying_mode = 1'b0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transaction", int'(out_data), 0);
        end else begin
          want = expected_q.pop_front();
          if (out_data.read_state !== want.read_state)
            report_mismatch("read_state", int'(out_data.read_state), int'(want.read_state));
          if (out_data.op_done !== want.op_done)
            report_mismatch("op_done", int'(out_data.op_done), int'(want.op_done));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BORN:  born_bits = cfg_data;
          REG_STAY:  stay_bits = cfg_data;
          REG_THREE: dying_mode = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_q = {expected_q, predict_result(in_data)};
    end
    pending = expected_q.size();
  end
endmodule

// ===== verif/life_like_3d_automaton_top_tb.sv =====
// testbench top for the 3d life-like automaton: stimulus and verdict
`timescale 1ns / 1ps
module life_like_3d_automaton_top_tb;
  import lla3_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [1:0] ST_BAD = 2'd3;
  localparam logic [MASK_W-1:0] ALL_ONES = '1;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  in_t               in_data;
  logic              out_valid;
  logic              out_stall;
  out_t              out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [MASK_W-1:0] cfg_data;
  logic              hold_req;
  logic              hold_done;
  int                fail_count;
  int                pending;

  life_like_3d_automaton_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  life_like_3d_automaton_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [3:0] near_coord();
    if ($urandom_range(0, 9) < 7) return 4'($urandom_range(0, 3));
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic send_cmd(logic [1:0] act, logic [3:0] x, logic [3:0] y, logic [3:0] z,
                          logic [1:0] st);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{action: act, cell_x: x, cell_y: y, cell_z: z, new_state: st};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [MASK_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_round(logic [MASK_W-1:0] born, logic [MASK_W-1:0] stay, logic three);
    int r;
    cfg_write(REG_BORN, born);
    cfg_write(REG_STAY, stay);
    cfg_write(REG_THREE, MASK_W'(three));
    for (int i = 0; i < 35; i++) begin
      r = $urandom_range(0, 19);
      if (r < 11)
        send_cmd(ACT_WRITE, near_coord(), near_coord(), near_coord(),
                 ($urandom_range(0, 9) < 7) ? ST_LIVE : 2'($urandom_range(0, 3)));
      else if (r < 19)
        send_cmd(ACT_READ, near_coord(), near_coord(), near_coord(), 2'($urandom_range(0, 3)));
      else
        send_cmd(ACT_NONE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
    end
    send_cmd(ACT_ADVANCE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
             4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
    for (int i = 0; i < 6; i++)
      send_cmd(ACT_READ, 4'($urandom_range(0, 4)), 4'($urandom_range(0, 4)),
               4'($urandom_range(0, 4)), 2'd0);
    drain();
  endtask

  // output side stalls, with one long hold when asked
  initial begin
    int g;
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
        hold_done <= 1'b1;
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_stall <= 1'b1;
          repeat (g) @(posedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_BORN;
    cfg_data = '0;
    hold_req = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    cfg_write(REG_BORN, ALL_ONES);
    cfg_write(REG_STAY, '0);
    cfg_write(REG_THREE, MASK_W'(1'b1));
    cfg_write(REG_UNUSED, ALL_ONES);

    send_cmd(ACT_WRITE, 4'd0, 4'd0, 4'd0, ST_LIVE);
    send_cmd(ACT_WRITE, 4'd15, 4'd15, 4'd15, ST_DYING);
    send_cmd(ACT_WRITE, 4'd15, 4'd0, 4'd15, ST_LIVE);
    send_cmd(ACT_WRITE, 4'd1, 4'd1, 4'd1, ST_BAD);
    send_cmd(ACT_WRITE, 4'd0, 4'd15, 4'd0, ST_DEAD);
    send_cmd(ACT_READ, 4'd0, 4'd0, 4'd0, ST_DEAD);
    send_cmd(ACT_READ, 4'd15, 4'd15, 4'd15, ST_DEAD);
    send_cmd(ACT_READ, 4'd1, 4'd1, 4'd1, ST_BAD);
    send_cmd(ACT_NONE, 4'd15, 4'd15, 4'd15, ST_BAD);
    send_cmd(ACT_ADVANCE, 4'd0, 4'd0, 4'd0, ST_DEAD);
    send_cmd(ACT_READ, 4'd0, 4'd0, 4'd0, ST_DEAD);
    send_cmd(ACT_READ, 4'd1, 4'd1, 4'd1, ST_DEAD);
    send_cmd(ACT_READ, 4'd15, 4'd15, 4'd15, ST_DEAD);
    send_cmd(ACT_READ, 4'd15, 4'd0, 4'd15, ST_DEAD);
    send_cmd(ACT_ADVANCE, 4'd15, 4'd15, 4'd15, ST_BAD);
    send_cmd(ACT_READ, 4'd0, 4'd0, 4'd0, ST_DEAD);
    send_cmd(ACT_READ, 4'd8, 4'd8, 4'd8, ST_DEAD);
    drain();

    hold_req <= 1'b1;
    random_round('0, ALL_ONES, 1'b0);
    random_round(MASK_W'($urandom_range(0, 32'h7FF_FFFF)),
                 MASK_W'($urandom_range(0, 32'h7FF_FFFF)), 1'b1);
    random_round(MASK_W'((1 << 4) | (1 << 5) | ($urandom_range(0, 255) << 8)),
                 MASK_W'((1 << 2) | (1 << 3) | (1 << 4) | ($urandom_range(0, 255) << 6)),
                 1'b0);

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
